/* rtl/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared widths, constants and the CORDIC arctangent table for the
// Euler-angle to quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_W      = 16;
  localparam int QUAT_W       = 16;
  localparam int WORK_FRAC    = 30;
  localparam int WORK_W       = 34;
  localparam int DEF_ANGLE_FRAC_BITS = 13;
  localparam int DEF_OUT_FRAC_BITS   = 14;
  localparam int DEF_CORDIC_STAGES   = 16;

  localparam logic signed [WORK_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [WORK_W-1:0] GAIN_Q30    = 34'sd652032874;

  typedef logic signed [WORK_W-1:0] work_t;

  typedef struct packed {
    work_t c;
    work_t s;
    work_t z;
  } cs_t;

  function automatic work_t atan_q30(input logic [4:0] i);
    work_t r;
    case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      5'd24: r = 34'sd64;
      5'd25: r = 34'sd32;
      5'd26: r = 34'sd16;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      5'd30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/e2q_cordic.sv */
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode CORDIC: one register stage per iteration, giving
// cosine and sine of the half angle in Q30. Advances only when en is high.
// ----------------------------------------------------------------------------
module e2q_cordic
  import e2q_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [ANGLE_W-1:0] angle,
  output work_t                     cos_q,
  output work_t                     sin_q
);

  localparam int SHL = 29 - ANGLE_FRAC_BITS;

  cs_t   st_r [CORDIC_STAGES+1];
  work_t z0;

  always_comb begin
    z0 = work_t'(angle) <<< SHL;
    if (z0 > HALF_PI_Q30) z0 = HALF_PI_Q30;
    if (z0 < -HALF_PI_Q30) z0 = -HALF_PI_Q30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= '{c: GAIN_Q30, s: '0, z: z0};
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    work_t dx, dy;
    assign dx = st_r[i].s >>> i;
    assign dy = st_r[i].c >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!st_r[i].z[WORK_W-1]) begin
          st_r[i+1] <= '{c: st_r[i].c - dx, s: st_r[i].s + dy,
                         z: st_r[i].z - atan_q30(5'(i))};
        end else begin
          st_r[i+1] <= '{c: st_r[i].c + dx, s: st_r[i].s - dy,
                         z: st_r[i].z + atan_q30(5'(i))};
        end
      end
    end
  end

  assign cos_q = st_r[CORDIC_STAGES].c;
  assign sin_q = st_r[CORDIC_STAGES].s;

endmodule

/* rtl/e2q_combine.sv */
// ----------------------------------------------------------------------------
// e2q_combine
// Triple products and sums: pair products, then triple products, then sums,
// then rounding and saturation, each behind a register. Advances on en.
// ----------------------------------------------------------------------------
module e2q_combine
  import e2q_pkg::*;
#(
  parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     en,
  input  work_t                    cr, sr, cp, sp, cy, sy,
  output logic signed [QUAT_W-1:0] qw, qx, qy, qz
);

  localparam int SH = WORK_FRAC - OUT_FRAC_BITS;

  // pair products: cy*cp, sy*sp, sy*cp, cy*sp
  work_t p_r [4];
  work_t r1_r [2];  // cr, sr delayed
  work_t t_r [8];
  work_t s_r [4];
  logic signed [QUAT_W-1:0] q_r [4];

  function automatic work_t mulq(input work_t a, input work_t b);
    logic signed [2*WORK_W-1:0] m;
    m = a * b;
    return work_t'(m >>> WORK_FRAC);
  endfunction

  function automatic logic signed [QUAT_W-1:0] fin(input work_t v);
    logic signed [WORK_W:0] r;
    logic signed [WORK_W:0] lim;
    lim = (WORK_W+1)'(1) <<< OUT_FRAC_BITS;
    if (SH > 0) r = ((WORK_W+1)'(v) + ((WORK_W+1)'(1) <<< (SH-1))) >>> SH;
    else r = (WORK_W+1)'(v);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    if (r > 32767) r = (WORK_W+1)'(32767);
    if (r < -32768) r = (WORK_W+1)'(-32768);
    return r[QUAT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= mulq(cy, cp);
      p_r[1] <= mulq(sy, sp);
      p_r[2] <= mulq(sy, cp);
      p_r[3] <= mulq(cy, sp);
      r1_r[0] <= cr;
      r1_r[1] <= sr;
      t_r[0] <= mulq(p_r[0], r1_r[0]);
      t_r[1] <= mulq(p_r[1], r1_r[1]);
      t_r[2] <= mulq(p_r[0], r1_r[1]);
      t_r[3] <= mulq(p_r[1], r1_r[0]);
      t_r[4] <= mulq(p_r[2], r1_r[1]);
      t_r[5] <= mulq(p_r[3], r1_r[0]);
      t_r[6] <= mulq(p_r[2], r1_r[0]);
      t_r[7] <= mulq(p_r[3], r1_r[1]);
      s_r[0] <= t_r[0] + t_r[1];
      s_r[1] <= t_r[2] - t_r[3];
      s_r[2] <= t_r[4] + t_r[5];
      s_r[3] <= t_r[6] - t_r[7];
      for (int k = 0; k < 4; k++) q_r[k] <= fin(s_r[k]);
    end
  end

  assign qw = q_r[0];
  assign qx = q_r[1];
  assign qy = q_r[2];
  assign qz = q_r[3];

endmodule

/* rtl/euler_angles_to_quaternion.sv */
// Throughput: one transaction per cycle while out_tready does not hold the
// output; the CORDIC iterations and the multiplier stages are fully pipelined.
// The whole pipeline freezes while the output is held by out_tready low.
// Reset (rst_n low, synchronous) clears the valid bits only.
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion
// Converts roll/pitch/yaw (Q2.13) to a unit quaternion (Q1.14).
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion
  import e2q_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  parameter int OUT_FRAC_BITS   = DEF_OUT_FRAC_BITS,
  parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // quat_w, quat_x, quat_y, quat_z
);

  localparam int LAT = CORDIC_STAGES + 5;

  logic  en;
  logic  vld_r [LAT];
  work_t cr, sr, cp, sp, cy, sy;
  logic signed [QUAT_W-1:0] qw, qx, qy, qz;

  // advance whenever the output slot is empty or being taken
  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  e2q_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .angle(in_tdata[15:0]), .cos_q(cr), .sin_q(sr));
  e2q_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .angle(in_tdata[31:16]), .cos_q(cp), .sin_q(sp));
  e2q_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en), .angle(in_tdata[47:32]), .cos_q(cy), .sin_q(sy));

  e2q_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_comb (
    .clk(clk), .en(en), .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
    .qw(qw), .qx(qx), .qy(qy), .qz(qz));

  assign out_tdata = {qz, qy, qx, qw};

endmodule

/* rtl/e2q_checker.sv */
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks for the quaternion converter.
// ----------------------------------------------------------------------------
module e2q_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");

  // input side open whenever output side empty or draining
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled without output backpressure");

  // quat_w never leaves the range -1.0 to +1.0 in Q1.14
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[15:0]) <= 16384 && $signed(out_tdata[15:0]) >= -16384)
    else $error("quat_w out of range");

  // no output right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid after reset");

endmodule

bind euler_angles_to_quaternion e2q_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));

/* dv/tb_euler_angles_to_quaternion.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_angles_to_quaternion
// Drives roll/pitch/yaw angle triples into the converter and compares every
// quaternion against a bit-true CORDIC and triple-product predictor, under
// several idle and backpressure patterns.
// ----------------------------------------------------------------------------
module tb_euler_angles_to_quaternion;
  import e2q_pkg::*;

  localparam int ANGLE_FRAC = DEF_ANGLE_FRAC_BITS;
  localparam int OUT_FRAC   = DEF_OUT_FRAC_BITS;
  localparam int STAGES     = DEF_CORDIC_STAGES;
  localparam int LATENCY    = STAGES + 5;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // roll_angle, pitch_angle, yaw_angle
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // quat_w, quat_x, quat_y, quat_z

  quat_t  expected_quats[$];
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     hold_off;
  int     mismatches;
  int     quats_checked;
  int     angles_sent;
  longint cycles;

  euler_angles_to_quaternion uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // floor shift of a 64-bit value; >>> on signed longint floors already
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arctan_q30(int i);
    longint t[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                      524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                      2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic void half_angle_sincos(input logic signed [15:0] ang,
                                            output longint c, output longint s);
    longint z, x, y, dx, dy;
    z = longint'(ang) * (longint'(1) << (29 - ANGLE_FRAC));
    x = 652032874;
    y = 0;
    if (z > 1686629713) z = 1686629713;
    if (z < -1686629713) z = -1686629713;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q30(i);
      end else begin
        x += dx; y -= dy; z += arctan_q30(i);
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint triple_product(longint a, longint b, longint c);
    return floor_shift(floor_shift(a * b, 30) * c, 30);
  endfunction

  function automatic logic signed [15:0] round_saturate(longint v);
    longint r, lim;
    lim = longint'(1) << OUT_FRAC;
    r = floor_shift(v + (longint'(1) << (29 - OUT_FRAC)), 30 - OUT_FRAC);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic quat_t predict_quat(angles_t a);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_angle_sincos(a.roll, cr, sr);
    half_angle_sincos(a.pitch, cp, sp);
    half_angle_sincos(a.yaw, cy, sy);
    q.w = round_saturate(triple_product(cy, cp, cr) + triple_product(sy, sp, sr));
    q.x = round_saturate(triple_product(cy, cp, sr) - triple_product(sy, sp, cr));
    q.y = round_saturate(triple_product(sy, cp, sr) + triple_product(cy, sp, cr));
    q.z = round_saturate(triple_product(sy, cp, cr) - triple_product(cy, sp, sr));
    return q;
  endfunction

  // offer one angle triple, with a random gap first, and wait for acceptance;
  // valid stays high after acceptance until a gap or drain drops it
  task automatic send_angles(input angles_t a);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= a;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_quats.push_back(predict_quat(a));
    angles_sent++;
  endtask

  function automatic logic signed [15:0] random_angle();
    case ($urandom_range(9))
      0: return 16'(int'($urandom_range(51472)) - 25736);
      1: return 16'($urandom());
      2: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'(int'($urandom_range(51472)) - 25736);
    endcase
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (expected_quats.size() > 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    logic signed [15:0] v[9] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767,
                                 -16'sd32768, 16'sd12868, -16'sd12868, 16'sd1, -16'sd1};
    for (int i = 0; i < 9; i++) send_angles('{yaw: 16'sd0, pitch: 16'sd0, roll: v[i]});
    for (int i = 1; i < 5; i++) send_angles('{yaw: 16'sd0, pitch: v[i], roll: 16'sd0});
    for (int i = 1; i < 5; i++) send_angles('{yaw: v[i], pitch: 16'sd0, roll: 16'sd0});
    send_angles('{yaw: 16'sd32767, pitch: 16'sd32767, roll: 16'sd32767});
    send_angles('{yaw: -16'sd32768, pitch: -16'sd32768, roll: -16'sd32768});
    send_angles('{yaw: 16'sd25736, pitch: -16'sd25736, roll: 16'sd12868});
    send_angles('{yaw: 16'sh5555, pitch: 16'shAAAA, roll: 16'sh5555});
    send_angles('{yaw: 16'shAAAA, pitch: 16'sh5555, roll: 16'shAAAA});
    drain();
  endtask

  task automatic test_random_phase(input int n, input int idle, input int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++)
      send_angles('{yaw: random_angle(), pitch: random_angle(), roll: random_angle()});
    drain();
  endtask

  // receiver holds off while the sender keeps offering, filling the pipeline
  task automatic test_backpressure_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    for (int i = 0; i < 60; i++)
      send_angles('{yaw: random_angle(), pitch: random_angle(), roll: random_angle()});
    drain();
  endtask

  initial begin : hold_off_timer
    forever begin
      @(posedge clk);
      if (hold_off) begin
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    quat_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quaternion %h", got);
      end else begin
        want = expected_quats.pop_front();
        quats_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    quats_checked = 0;
    angles_sent = 0;
    cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_random_phase(320, 0, 0);
    test_random_phase(320, 47, 0);
    test_random_phase(320, 0, 47);
    test_random_phase(320, 18, 18);
    test_backpressure_fill();
    if (expected_quats.size() != 0) begin
      mismatches++;
      $display("%0d quaternions never arrived", expected_quats.size());
    end
    $display("covered %0d angle triples, %0d quaternions checked, %0d mismatches",
             angles_sent, quats_checked, mismatches);
    $display("phases: directed extremes, free flow, sender gaps, receiver stalls, both, fill");
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
